FILE: hdl/vmmio_pkg.sv
// Package of types and constants for the virtio-mmio register block.
package vmmio_pkg;

  localparam int unsigned MaxQueues = 8;
  localparam int unsigned QIdxW     = $clog2(MaxQueues);
  localparam int unsigned QCountW   = 4;

  localparam logic [31:0] MagicWord   = 32'h7472_6976;
  localparam logic [31:0] VersionWord = 32'd2;
  localparam logic [63:0] FeatVersionOne = 64'h0000_0001_0000_0000;
  localparam int unsigned StatusFeaturesOkBit = 3;

  // Transaction opcodes.
  localparam logic [1:0] OpRead  = 2'd0;
  localparam logic [1:0] OpWrite = 2'd1;
  localparam logic [1:0] OpUsed  = 2'd2;

  // Access sizes in bytes.
  localparam logic [3:0] Size1 = 4'd1;
  localparam logic [3:0] Size2 = 4'd2;
  localparam logic [3:0] Size4 = 4'd4;

  // Register window offsets.
  localparam logic [11:0] OffMagic        = 12'h000;
  localparam logic [11:0] OffVersion      = 12'h004;
  localparam logic [11:0] OffDeviceId     = 12'h008;
  localparam logic [11:0] OffVendorId     = 12'h00C;
  localparam logic [11:0] OffDevFeat      = 12'h010;
  localparam logic [11:0] OffDevFeatSel   = 12'h014;
  localparam logic [11:0] OffDrvFeat      = 12'h020;
  localparam logic [11:0] OffDrvFeatSel   = 12'h024;
  localparam logic [11:0] OffQueueSel     = 12'h030;
  localparam logic [11:0] OffQueueNumMax  = 12'h034;
  localparam logic [11:0] OffQueueNum     = 12'h038;
  localparam logic [11:0] OffQueueReady   = 12'h044;
  localparam logic [11:0] OffQueueNotify  = 12'h050;
  localparam logic [11:0] OffIntStatus    = 12'h060;
  localparam logic [11:0] OffIntAck       = 12'h064;
  localparam logic [11:0] OffStatus       = 12'h070;
  localparam logic [11:0] OffDescLow      = 12'h080;
  localparam logic [11:0] OffDescHigh     = 12'h084;
  localparam logic [11:0] OffAvailLow     = 12'h090;
  localparam logic [11:0] OffAvailHigh    = 12'h094;
  localparam logic [11:0] OffUsedLow      = 12'h0A0;
  localparam logic [11:0] OffUsedHigh     = 12'h0A4;

  // Configuration register indexes (byte address is eight times the index).
  localparam logic [2:0] CfgDeviceId     = 3'd0;
  localparam logic [2:0] CfgVendorId     = 3'd1;
  localparam logic [2:0] CfgDeviceFeat   = 3'd2;
  localparam logic [2:0] CfgQueueCount   = 3'd3;
  localparam logic [2:0] CfgQueueSizeMax = 3'd4;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [11:0] reg_offset;
    logic [3:0]  access_size;
    logic [31:0] write_data;
  } vmmio_req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        access_ok;
    logic        irq_level;
    logic        notify_pulse;
    logic [15:0] notify_idx;
    logic        ready_pulse;
    logic [15:0] ready_queue;
  } vmmio_rsp_t;

  function automatic logic [31:0] size_mask(input logic [31:0] v, input logic [3:0] size);
    logic [31:0] r;
    r = v;
    if (size == Size1) begin
      r = {24'd0, v[7:0]};
    end else if (size == Size2) begin
      r = {16'd0, v[15:0]};
    end
    return r;
  endfunction

endpackage

FILE: hdl/virtio_mmio_register_block.sv
// Virtio-mmio version 2 transport register file with an APB configuration port.
// A transaction taken at a clock edge has its result on rsp_o, marked by
// done_o, during the following cycle; one transaction can be taken every cycle.
// busy is never raised, since every transaction is a single decode and update.
// The result is shown for exactly one cycle; the receiver cannot stall it.
// Reset (rst_ni low, asynchronous) clears all transport state and restores the
// configuration registers to their reset values; no clearing pass is needed.
module virtio_mmio_register_block (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  vmmio_pkg::vmmio_req_t  req_i,
  output logic                   done_o,
  output vmmio_pkg::vmmio_rsp_t  rsp_o,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [5:0]             paddr,
  input  logic [63:0]            pwdata,
  output logic [63:0]            prdata,
  output logic                   pready
);

  localparam int unsigned NQ = vmmio_pkg::MaxQueues;
  localparam int unsigned QW = vmmio_pkg::QIdxW;

  // Configuration registers, written through the APB port.
  logic [15:0] cfg_device_id_q;
  logic [31:0] cfg_vendor_id_q;
  logic [63:0] cfg_dev_feat_q;
  logic [vmmio_pkg::QCountW-1:0] cfg_queue_count_q;
  logic [15:0] cfg_qsize_max_q;

  // Transport state. Only bit 0 of the interrupt status can ever be set (used
  // ring), so a single flop holds it and the interrupt line follows it directly.
  logic [31:0] dev_feat_sel_q, dev_feat_sel_d;
  logic [31:0] drv_feat_sel_q, drv_feat_sel_d;
  logic [63:0] drv_feat_q, drv_feat_d;
  logic [31:0] cur_queue_q, cur_queue_d;
  logic        int_used_q, int_used_d;
  logic [31:0] status_q, status_d;

  logic [15:0] ring_size_q [NQ];
  logic [15:0] ring_size_d [NQ];
  logic [NQ-1:0] ring_ready_q, ring_ready_d;
  logic [63:0] desc_q  [NQ];
  logic [63:0] desc_d  [NQ];
  logic [63:0] avail_q [NQ];
  logic [63:0] avail_d [NQ];
  logic [63:0] used_q  [NQ];
  logic [63:0] used_d  [NQ];

  // Result register.
  vmmio_pkg::vmmio_rsp_t rsp_q, rsp_d;
  logic                  done_q;

  logic accept;
  logic cfg_wr;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign accept = start & ~busy;
  assign cfg_wr = psel & penable & pwrite & pready;

  // ---------------------------------------------------------------------------
  // Configuration port. Register i sits at byte address 8*i; reads are
  // combinational from the registers, writes beyond the list are dropped.
  // ---------------------------------------------------------------------------
  always_comb begin
    prdata = '0;
    unique case (paddr[5:3])
      vmmio_pkg::CfgDeviceId:     prdata = {48'd0, cfg_device_id_q};
      vmmio_pkg::CfgVendorId:     prdata = {32'd0, cfg_vendor_id_q};
      vmmio_pkg::CfgDeviceFeat:   prdata = cfg_dev_feat_q;
      vmmio_pkg::CfgQueueCount:   prdata = {60'd0, cfg_queue_count_q};
      vmmio_pkg::CfgQueueSizeMax: prdata = {48'd0, cfg_qsize_max_q};
      default:                    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_device_id_q   <= '0;
      cfg_vendor_id_q   <= '0;
      cfg_dev_feat_q    <= vmmio_pkg::FeatVersionOne;
      cfg_queue_count_q <= '0;
      cfg_qsize_max_q   <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[5:3])
        vmmio_pkg::CfgDeviceId:     cfg_device_id_q   <= pwdata[15:0];
        vmmio_pkg::CfgVendorId:     cfg_vendor_id_q   <= pwdata[31:0];
        // The VERSION_1 feature bit is always offered.
        vmmio_pkg::CfgDeviceFeat:   cfg_dev_feat_q    <= pwdata | vmmio_pkg::FeatVersionOne;
        vmmio_pkg::CfgQueueCount:   cfg_queue_count_q <= pwdata[vmmio_pkg::QCountW-1:0];
        vmmio_pkg::CfgQueueSizeMax: cfg_qsize_max_q   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Queue selection. The selected queue exists only when it lies below the
  // smaller of the configured queue count and the number of queue slots.
  // ---------------------------------------------------------------------------
  logic [vmmio_pkg::QCountW-1:0] q_limit;
  logic                          q_valid;
  logic [QW-1:0]                 q_idx;

  always_comb begin
    if ({28'd0, cfg_queue_count_q} > NQ) begin
      q_limit = vmmio_pkg::QCountW'(NQ);
    end else begin
      q_limit = cfg_queue_count_q;
    end
    q_valid = cur_queue_q < {{(32 - vmmio_pkg::QCountW){1'b0}}, q_limit};
    q_idx   = q_valid ? cur_queue_q[QW-1:0] : '0;
  end

  // ---------------------------------------------------------------------------
  // Transaction decode: read mux, register updates and the result word.
  // ---------------------------------------------------------------------------
  logic        size_ok;
  logic [31:0] wdata;
  logic [31:0] rd_raw;
  logic        feat_bad;

  assign size_ok = (req_i.access_size == vmmio_pkg::Size1) ||
                   (req_i.access_size == vmmio_pkg::Size2) ||
                   (req_i.access_size == vmmio_pkg::Size4);
  assign wdata    = vmmio_pkg::size_mask(req_i.write_data, req_i.access_size);
  // The driver has accepted a feature the device never offered.
  assign feat_bad = |(drv_feat_q & ~cfg_dev_feat_q);

  always_comb begin
    rd_raw = '0;
    unique case (req_i.reg_offset)
      vmmio_pkg::OffMagic:       rd_raw = vmmio_pkg::MagicWord;
      vmmio_pkg::OffVersion:     rd_raw = vmmio_pkg::VersionWord;
      vmmio_pkg::OffDeviceId:    rd_raw = {16'd0, cfg_device_id_q};
      vmmio_pkg::OffVendorId:    rd_raw = cfg_vendor_id_q;
      vmmio_pkg::OffDevFeat:     rd_raw = (dev_feat_sel_q == '0) ? cfg_dev_feat_q[31:0]
                                                                 : cfg_dev_feat_q[63:32];
      vmmio_pkg::OffQueueNumMax: rd_raw = q_valid ? {16'd0, cfg_qsize_max_q} : '0;
      vmmio_pkg::OffQueueNum:    rd_raw = q_valid ? {16'd0, ring_size_q[q_idx]} : '0;
      vmmio_pkg::OffQueueReady:  rd_raw = {31'd0, q_valid & ring_ready_q[q_idx]};
      vmmio_pkg::OffIntStatus:   rd_raw = {31'd0, int_used_q};
      vmmio_pkg::OffStatus:      rd_raw = status_q;
      vmmio_pkg::OffDescLow:     rd_raw = q_valid ? desc_q[q_idx][31:0]   : '0;
      vmmio_pkg::OffDescHigh:    rd_raw = q_valid ? desc_q[q_idx][63:32]  : '0;
      vmmio_pkg::OffAvailLow:    rd_raw = q_valid ? avail_q[q_idx][31:0]  : '0;
      vmmio_pkg::OffAvailHigh:   rd_raw = q_valid ? avail_q[q_idx][63:32] : '0;
      vmmio_pkg::OffUsedLow:     rd_raw = q_valid ? used_q[q_idx][31:0]   : '0;
      vmmio_pkg::OffUsedHigh:    rd_raw = q_valid ? used_q[q_idx][63:32]  : '0;
      default:                   rd_raw = '0;
    endcase
  end

  always_comb begin
    dev_feat_sel_d = dev_feat_sel_q;
    drv_feat_sel_d = drv_feat_sel_q;
    drv_feat_d     = drv_feat_q;
    cur_queue_d    = cur_queue_q;
    int_used_d     = int_used_q;
    status_d       = status_q;
    ring_ready_d   = ring_ready_q;
    ring_size_d    = ring_size_q;
    desc_d         = desc_q;
    avail_d        = avail_q;
    used_d         = used_q;
    rsp_d          = '0;

    if (accept) begin
      unique case (req_i.opcode)
        vmmio_pkg::OpRead: begin
          if (size_ok) begin
            rsp_d.access_ok = 1'b1;
            rsp_d.read_data = vmmio_pkg::size_mask(rd_raw, req_i.access_size);
          end
        end
        vmmio_pkg::OpWrite: begin
          if (size_ok) begin
            rsp_d.access_ok = 1'b1;
            unique case (req_i.reg_offset)
              vmmio_pkg::OffDevFeatSel: dev_feat_sel_d = wdata;
              vmmio_pkg::OffDrvFeat: begin
                if (drv_feat_sel_q != '0) begin
                  drv_feat_d[63:32] = wdata;
                end else begin
                  drv_feat_d[31:0] = wdata;
                end
              end
              vmmio_pkg::OffDrvFeatSel: drv_feat_sel_d = wdata;
              vmmio_pkg::OffQueueSel:   cur_queue_d    = wdata;
              vmmio_pkg::OffQueueNum: begin
                if (q_valid && (wdata <= {16'd0, cfg_qsize_max_q})) begin
                  ring_size_d[q_idx] = wdata[15:0];
                end
              end
              vmmio_pkg::OffQueueReady: begin
                if (q_valid) begin
                  ring_ready_d[q_idx] = (wdata != '0);
                  if (wdata != '0) begin
                    rsp_d.ready_pulse = 1'b1;
                    rsp_d.ready_queue = cur_queue_q[15:0];
                  end
                end
              end
              vmmio_pkg::OffQueueNotify: begin
                rsp_d.notify_pulse = 1'b1;
                rsp_d.notify_idx   = wdata[15:0];
              end
              vmmio_pkg::OffIntAck: int_used_d = int_used_q & ~wdata[0];
              vmmio_pkg::OffStatus: begin
                if (wdata == '0) begin
                  // A status write of zero is a device reset of the transport.
                  dev_feat_sel_d = '0;
                  drv_feat_sel_d = '0;
                  drv_feat_d     = '0;
                  cur_queue_d    = '0;
                  int_used_d     = 1'b0;
                  status_d       = '0;
                  ring_ready_d   = '0;
                  for (int i = 0; i < NQ; i++) begin
                    ring_size_d[i] = '0;
                    desc_d[i]      = '0;
                    avail_d[i]     = '0;
                    used_d[i]      = '0;
                  end
                end else begin
                  status_d = wdata;
                  if (wdata[vmmio_pkg::StatusFeaturesOkBit] && feat_bad) begin
                    status_d[vmmio_pkg::StatusFeaturesOkBit] = 1'b0;
                  end
                end
              end
              vmmio_pkg::OffDescLow:   if (q_valid) desc_d[q_idx][31:0]   = wdata;
              vmmio_pkg::OffDescHigh:  if (q_valid) desc_d[q_idx][63:32]  = wdata;
              vmmio_pkg::OffAvailLow:  if (q_valid) avail_d[q_idx][31:0]  = wdata;
              vmmio_pkg::OffAvailHigh: if (q_valid) avail_d[q_idx][63:32] = wdata;
              vmmio_pkg::OffUsedLow:   if (q_valid) used_d[q_idx][31:0]   = wdata;
              vmmio_pkg::OffUsedHigh:  if (q_valid) used_d[q_idx][63:32]  = wdata;
              default: ;
            endcase
          end
        end
        vmmio_pkg::OpUsed: begin
          // A used-ring event is taken whatever its size or offset.
          rsp_d.access_ok = 1'b1;
          int_used_d      = 1'b1;
        end
        default: ;
      endcase
      rsp_d.irq_level = int_used_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_feat_sel_q <= '0;
      drv_feat_sel_q <= '0;
      drv_feat_q     <= '0;
      cur_queue_q    <= '0;
      int_used_q     <= 1'b0;
      status_q       <= '0;
      ring_ready_q   <= '0;
      for (int i = 0; i < NQ; i++) begin
        ring_size_q[i] <= '0;
        desc_q[i]      <= '0;
        avail_q[i]     <= '0;
        used_q[i]      <= '0;
      end
      done_q <= 1'b0;
    end else begin
      dev_feat_sel_q <= dev_feat_sel_d;
      drv_feat_sel_q <= drv_feat_sel_d;
      drv_feat_q     <= drv_feat_d;
      cur_queue_q    <= cur_queue_d;
      int_used_q     <= int_used_d;
      status_q       <= status_d;
      ring_ready_q   <= ring_ready_d;
      ring_size_q    <= ring_size_d;
      desc_q         <= desc_d;
      avail_q        <= avail_d;
      used_q         <= used_d;
      done_q         <= accept;
    end
  end

  // The result word is payload and needs no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

FILE: tb/tb_virtio_mmio_register_block.sv
// Self-checking testbench for the virtio-mmio transport register block.
module tb_virtio_mmio_register_block;
  timeunit 1ns;
  timeprecision 1ps;

  // Offsets from here up belong to device config space, which the block does not model.
  localparam logic [11:0] ConfigSpaceStart = 12'h100;

  // The opcode that the block does not use.
  localparam logic [1:0] OpUnused = 2'd3;

  // Device status bits as a driver sets them during bring-up.
  localparam logic [31:0] StAcknowledge = 32'h1;
  localparam logic [31:0] StDriver      = 32'h2;
  localparam logic [31:0] StDriverOk    = 32'h4;
  localparam logic [31:0] StFeaturesOk  = 32'h8;

  localparam logic [31:0] IntUsedRing = 32'h1;

  localparam string PassMsg = "tb_virtio_mmio_register_block: done, clean";

  logic                  clk_i   = 1'b0;
  logic                  rst_ni  = 1'b0;
  logic                  start   = 1'b0;
  logic                  busy;
  vmmio_pkg::vmmio_req_t req_i   = '0;
  logic                  done_o;
  vmmio_pkg::vmmio_rsp_t rsp_o;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [5:0]            paddr   = '0;
  logic [63:0]           pwdata  = '0;
  logic [63:0]           prdata;
  logic                  pready;

  virtio_mmio_register_block u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .req_i   (req_i),
    .done_o  (done_o),
    .rsp_o   (rsp_o),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Bus accesses waiting to be driven, and the replies predicted for accepted ones.
  vmmio_pkg::vmmio_req_t bus_requests[$];
  vmmio_pkg::vmmio_rsp_t predicted_replies[$];

  int   queued_count = 0;
  int   fail_count   = 0;
  logic item_taken   = 1'b0;
  logic bursty       = 1'b1;
  int   gap_left     = 0;

  // Our own copy of the configuration registers, updated as APB writes land.
  logic [15:0] id_dev;
  logic [31:0] id_vendor;
  logic [63:0] offered_feat;
  logic [3:0]  num_queues;
  logic [15:0] ring_num_max;

  // Our own copy of the transport state.
  logic [31:0] dev_feat_sel;
  logic [31:0] drv_feat_sel;
  logic [63:0] drv_feat;
  logic [31:0] cur_queue;
  logic [31:0] int_status;
  logic [31:0] dev_status;
  logic        irq_line;
  logic [15:0] ring_num   [vmmio_pkg::MaxQueues];
  logic        ring_rdy   [vmmio_pkg::MaxQueues];
  logic [63:0] ring_desc  [vmmio_pkg::MaxQueues];
  logic [63:0] ring_avail [vmmio_pkg::MaxQueues];
  logic [63:0] ring_used  [vmmio_pkg::MaxQueues];

  // The clock runs with a 2 ns period from time zero.
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Writing status 0 and the hardware reset both return the transport to this state;
  // the configuration registers are left alone here.
  function automatic void wipe_transport();
    dev_feat_sel = '0;
    drv_feat_sel = '0;
    drv_feat     = '0;
    cur_queue    = '0;
    int_status   = '0;
    dev_status   = '0;
    irq_line     = 1'b0;
    foreach (ring_num[i]) begin
      ring_num[i]   = '0;
      ring_rdy[i]   = 1'b0;
      ring_desc[i]  = '0;
      ring_avail[i] = '0;
      ring_used[i]  = '0;
    end
  endfunction

  // Narrow a value to the width of a 1- or 2-byte access; 4-byte accesses pass it whole.
  function automatic logic [31:0] trim_to_size(input logic [31:0] v, input logic [3:0] sz);
    if (sz == vmmio_pkg::Size1) begin
      return v & 32'h0000_00ff;
    end
    if (sz == vmmio_pkg::Size2) begin
      return v & 32'h0000_ffff;
    end
    return v;
  endfunction

  // Predict the reply to one accepted transaction and advance the transport state.
  function automatic vmmio_pkg::vmmio_rsp_t transport_access(input vmmio_pkg::vmmio_req_t r);
    vmmio_pkg::vmmio_rsp_t       o;
    logic                        size_ok;
    logic                        qv;
    logic [vmmio_pkg::QIdxW-1:0] q;
    logic [31:0]                 lim;
    logic [31:0]                 v;
    logic [31:0]                 rd;
    o = '0;
    size_ok = (r.access_size == vmmio_pkg::Size1) || (r.access_size == vmmio_pkg::Size2) ||
              (r.access_size == vmmio_pkg::Size4);
    // A queue exists only below the smaller of the configured count and the hardware limit.
    lim = (num_queues > vmmio_pkg::MaxQueues) ? vmmio_pkg::MaxQueues : 32'(num_queues);
    qv  = cur_queue < lim;
    q   = qv ? cur_queue[vmmio_pkg::QIdxW-1:0] : '0;
    v   = trim_to_size(r.write_data, r.access_size);
    case (r.opcode)
      vmmio_pkg::OpRead: begin
        if (size_ok) begin
          o.access_ok = 1'b1;
          rd = '0;
          if (r.reg_offset < ConfigSpaceStart) begin
            case (r.reg_offset)
              vmmio_pkg::OffMagic:       rd = vmmio_pkg::MagicWord;
              vmmio_pkg::OffVersion:     rd = vmmio_pkg::VersionWord;
              vmmio_pkg::OffDeviceId:    rd = 32'(id_dev);
              vmmio_pkg::OffVendorId:    rd = id_vendor;
              // Any non-zero select picks the upper half of the feature word.
              vmmio_pkg::OffDevFeat:     rd = (dev_feat_sel == 0) ? offered_feat[31:0] :
                                                                    offered_feat[63:32];
              vmmio_pkg::OffQueueNumMax: rd = qv ? 32'(ring_num_max) : '0;
              vmmio_pkg::OffQueueNum:    rd = qv ? 32'(ring_num[q]) : '0;
              vmmio_pkg::OffQueueReady:  rd = (qv && ring_rdy[q]) ? 32'd1 : 32'd0;
              vmmio_pkg::OffIntStatus:   rd = int_status;
              vmmio_pkg::OffStatus:      rd = dev_status;
              vmmio_pkg::OffDescLow:     rd = qv ? ring_desc[q][31:0]   : '0;
              vmmio_pkg::OffDescHigh:    rd = qv ? ring_desc[q][63:32]  : '0;
              vmmio_pkg::OffAvailLow:    rd = qv ? ring_avail[q][31:0]  : '0;
              vmmio_pkg::OffAvailHigh:   rd = qv ? ring_avail[q][63:32] : '0;
              vmmio_pkg::OffUsedLow:     rd = qv ? ring_used[q][31:0]   : '0;
              vmmio_pkg::OffUsedHigh:    rd = qv ? ring_used[q][63:32]  : '0;
              default:                   rd = '0;
            endcase
          end
          o.read_data = trim_to_size(rd, r.access_size);
        end
      end
      vmmio_pkg::OpWrite: begin
        if (size_ok) begin
          o.access_ok = 1'b1;
          if (r.reg_offset < ConfigSpaceStart) begin
            case (r.reg_offset)
              vmmio_pkg::OffDevFeatSel: dev_feat_sel = v;
              vmmio_pkg::OffDrvFeat: begin
                if (drv_feat_sel != 0) begin
                  drv_feat[63:32] = v;
                end else begin
                  drv_feat[31:0] = v;
                end
              end
              vmmio_pkg::OffDrvFeatSel: drv_feat_sel = v;
              vmmio_pkg::OffQueueSel:   cur_queue = v;
              vmmio_pkg::OffQueueNum: begin
                // Sizes above the advertised maximum are dropped.
                if (qv && v <= 32'(ring_num_max)) begin
                  ring_num[q] = v[15:0];
                end
              end
              vmmio_pkg::OffQueueReady: begin
                if (qv) begin
                  ring_rdy[q] = (v != 0);
                  if (v != 0) begin
                    o.ready_pulse = 1'b1;
                    o.ready_queue = cur_queue[15:0];
                  end
                end
              end
              vmmio_pkg::OffQueueNotify: begin
                o.notify_pulse = 1'b1;
                o.notify_idx   = v[15:0];
              end
              vmmio_pkg::OffIntAck: begin
                int_status = int_status & ~v;
                irq_line   = (int_status != 0);
              end
              vmmio_pkg::OffStatus: begin
                if (v == 0) begin
                  wipe_transport();
                end else begin
                  dev_status = v;
                  // FEATURES_OK does not stick if the driver asked for anything not offered.
                  if ((v & StFeaturesOk) != 0 && (drv_feat & ~offered_feat) != 0) begin
                    dev_status = dev_status & ~StFeaturesOk;
                  end
                end
              end
              vmmio_pkg::OffDescLow:   if (qv) ring_desc[q][31:0]   = v;
              vmmio_pkg::OffDescHigh:  if (qv) ring_desc[q][63:32]  = v;
              vmmio_pkg::OffAvailLow:  if (qv) ring_avail[q][31:0]  = v;
              vmmio_pkg::OffAvailHigh: if (qv) ring_avail[q][63:32] = v;
              vmmio_pkg::OffUsedLow:   if (qv) ring_used[q][31:0]   = v;
              vmmio_pkg::OffUsedHigh:  if (qv) ring_used[q][63:32]  = v;
              default: ;
            endcase
          end
        end
      end
      vmmio_pkg::OpUsed: begin
        // A used-ring event is taken whatever its size and offset.
        o.access_ok = 1'b1;
        int_status  = int_status | IntUsedRing;
        irq_line    = 1'b1;
      end
      default: ;
    endcase
    o.irq_level = irq_line;
    return o;
  endfunction

  task automatic tally(input string fname, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("%0t: %s mismatch, expected %h, got %h", $realtime, fname, want, got);
      end
    end
  endtask

  // Driver: at each falling edge, retire the transaction the last rising edge took and
  // present the next one, or idle for a random burst while bursty idling is enabled.
  // Each of start and req_i gets exactly one nonblocking assignment per edge.
  always @(negedge clk_i) begin : drive_requests
    logic                  nxt_start;
    vmmio_pkg::vmmio_req_t nxt_req;
    nxt_start = start;
    nxt_req   = req_i;
    if (start && item_taken) begin
      nxt_start = 1'b0;
    end
    if (!nxt_start && rst_ni) begin
      if (gap_left != 0) begin
        gap_left = gap_left - 1;
      end else if (bus_requests.size() != 0 && bursty && $urandom_range(0, 7) == 0) begin
        // This cycle is the first of the idle burst.
        gap_left = $urandom_range(1, 11) - 1;
      end else if (bus_requests.size() != 0) begin
        nxt_start = 1'b1;
        nxt_req   = bus_requests.pop_front();
      end
    end
    start <= nxt_start;
    req_i <= nxt_req;
  end

  // Monitor: at each rising edge, check a strobed reply against the oldest prediction,
  // follow configuration writes, and predict the reply to a transaction taken at this edge.
  always @(posedge clk_i) begin : watch_bus
    vmmio_pkg::vmmio_rsp_t want;
    if (!rst_ni) begin
      item_taken   = 1'b0;
      id_dev       = '0;
      id_vendor    = '0;
      offered_feat = vmmio_pkg::FeatVersionOne;
      num_queues   = '0;
      ring_num_max = '0;
      wipe_transport();
    end else begin
      if (done_o) begin
        if (predicted_replies.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("%0t: reply with no transaction outstanding: %h", $realtime, rsp_o);
          end
        end else begin
          want = predicted_replies.pop_front();
          tally("read_data",    want.read_data,           rsp_o.read_data);
          tally("access_ok",    32'(want.access_ok),      32'(rsp_o.access_ok));
          tally("irq_level",    32'(want.irq_level),      32'(rsp_o.irq_level));
          tally("notify_pulse", 32'(want.notify_pulse),   32'(rsp_o.notify_pulse));
          tally("notify_idx",   32'(want.notify_idx),     32'(rsp_o.notify_idx));
          tally("ready_pulse",  32'(want.ready_pulse),    32'(rsp_o.ready_pulse));
          tally("ready_queue",  32'(want.ready_queue),    32'(rsp_o.ready_queue));
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[5:3])
          vmmio_pkg::CfgDeviceId:     id_dev       = pwdata[15:0];
          vmmio_pkg::CfgVendorId:     id_vendor    = pwdata[31:0];
          vmmio_pkg::CfgDeviceFeat:   offered_feat = pwdata | vmmio_pkg::FeatVersionOne;
          vmmio_pkg::CfgQueueCount:   num_queues   = pwdata[3:0];
          vmmio_pkg::CfgQueueSizeMax: ring_num_max = pwdata[15:0];
          default: ;
        endcase
      end
      item_taken = start && !busy;
      if (item_taken) begin
        predicted_replies.push_back(transport_access(req_i));
      end
    end
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #1_000_000;
    $display("tb_virtio_mmio_register_block: done, errors");
    $finish;
  end

  task automatic post_access(input logic [1:0] op, input logic [11:0] off,
                             input logic [3:0] sz, input logic [31:0] data);
    vmmio_pkg::vmmio_req_t r;
    r.opcode      = op;
    r.reg_offset  = off;
    r.access_size = sz;
    r.write_data  = data;
    bus_requests.push_back(r);
    queued_count++;
  endtask

  // Mostly full-word accesses, as drivers issue them, with some narrow ones.
  function automatic logic [3:0] any_size();
    case ($urandom_range(0, 5))
      0:       return vmmio_pkg::Size1;
      1:       return vmmio_pkg::Size2;
      default: return vmmio_pkg::Size4;
    endcase
  endfunction

  function automatic logic [11:0] any_offset();
    case ($urandom_range(0, 21))
      0:       return vmmio_pkg::OffMagic;
      1:       return vmmio_pkg::OffVersion;
      2:       return vmmio_pkg::OffDeviceId;
      3:       return vmmio_pkg::OffVendorId;
      4:       return vmmio_pkg::OffDevFeat;
      5:       return vmmio_pkg::OffDevFeatSel;
      6:       return vmmio_pkg::OffDrvFeat;
      7:       return vmmio_pkg::OffDrvFeatSel;
      8:       return vmmio_pkg::OffQueueSel;
      9:       return vmmio_pkg::OffQueueNumMax;
      10:      return vmmio_pkg::OffQueueNum;
      11:      return vmmio_pkg::OffQueueReady;
      12:      return vmmio_pkg::OffQueueNotify;
      13:      return vmmio_pkg::OffIntStatus;
      14:      return vmmio_pkg::OffIntAck;
      15:      return vmmio_pkg::OffStatus;
      16:      return vmmio_pkg::OffDescLow;
      17:      return vmmio_pkg::OffDescHigh;
      18:      return vmmio_pkg::OffAvailLow;
      19:      return vmmio_pkg::OffAvailHigh;
      20:      return vmmio_pkg::OffUsedLow;
      default: return vmmio_pkg::OffUsedHigh;
    endcase
  endfunction

  function automatic logic [11:0] ring_reg(input int j);
    case (j)
      0:       return vmmio_pkg::OffDescLow;
      1:       return vmmio_pkg::OffDescHigh;
      2:       return vmmio_pkg::OffAvailLow;
      3:       return vmmio_pkg::OffAvailHigh;
      4:       return vmmio_pkg::OffUsedLow;
      default: return vmmio_pkg::OffUsedHigh;
    endcase
  endfunction

  // A burst of arbitrary transactions: any opcode including the unused one, decoded,
  // misaligned and random offsets, and occasionally an illegal access size.
  task automatic post_noise(input int n);
    logic [11:0] off;
    logic [3:0]  sz;
    int          k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 3);
      if (k < 2) begin
        off = any_offset();
      end else if (k == 2) begin
        off = any_offset() | 12'($urandom_range(1, 3));
      end else begin
        off = 12'($urandom);
      end
      sz = ($urandom_range(0, 3) != 0) ? any_size() : 4'($urandom);
      post_access(2'($urandom), off, sz, $urandom);
    end
  endtask

  // One driver bring-up as the virtio spec lays it out: identify the device, negotiate
  // features, set up a few queues, go live, then notify, take interrupts and acknowledge.
  task automatic post_bringup();
    logic [63:0] feat;
    logic [31:0] sel;
    logic [31:0] num;
    int          nq;
    int          acts;
    if ($urandom_range(0, 2) == 0) begin
      post_access(vmmio_pkg::OpWrite, vmmio_pkg::OffStatus, vmmio_pkg::Size4, '0);
    end
    post_access(vmmio_pkg::OpRead, vmmio_pkg::OffMagic, any_size(), $urandom);
    post_access(vmmio_pkg::OpRead, vmmio_pkg::OffVersion, any_size(), $urandom);
    post_access(vmmio_pkg::OpRead, vmmio_pkg::OffDeviceId, any_size(), $urandom);
    post_access(vmmio_pkg::OpRead, vmmio_pkg::OffVendorId, any_size(), $urandom);
    post_access(vmmio_pkg::OpWrite, vmmio_pkg::OffStatus, vmmio_pkg::Size4, StAcknowledge);
    post_access(vmmio_pkg::OpWrite, vmmio_pkg::OffStatus, vmmio_pkg::Size4,
                StAcknowledge | StDriver);
    post_access(vmmio_pkg::OpWrite, vmmio_pkg::OffDevFeatSel, any_size(), '0);
    post_access(vmmio_pkg::OpRead, vmmio_pkg::OffDevFeat, any_size(), $urandom);
    post_access(vmmio_pkg::OpWrite, vmmio_pkg::OffDevFeatSel, vmmio_pkg::Size4,
                $urandom_range(0, 1) ? 32'd1 : $urandom);
    post_access(vmmio_pkg::OpRead, vmmio_pkg::OffDevFeat, any_size(), $urandom);
    // Usually the driver asks only for offered features; sometimes it over-asks.
    feat = {$urandom, $urandom};
    if ($urandom_range(0, 3) != 0) begin
      feat = feat & offered_feat;
    end
    post_access(vmmio_pkg::OpWrite, vmmio_pkg::OffDrvFeatSel, vmmio_pkg::Size4, '0);
    post_access(vmmio_pkg::OpWrite, vmmio_pkg::OffDrvFeat, any_size(), feat[31:0]);
    post_access(vmmio_pkg::OpWrite, vmmio_pkg::OffDrvFeatSel, vmmio_pkg::Size4,
                $urandom_range(0, 1) ? 32'd1 : $urandom);
    post_access(vmmio_pkg::OpWrite, vmmio_pkg::OffDrvFeat, any_size(), feat[63:32]);
    post_access(vmmio_pkg::OpWrite, vmmio_pkg::OffStatus, vmmio_pkg::Size4,
                StAcknowledge | StDriver | StFeaturesOk);
    post_access(vmmio_pkg::OpRead, vmmio_pkg::OffStatus, any_size(), $urandom);
    nq = $urandom_range(1, 3);
    for (int i = 0; i < nq; i++) begin
      sel = ($urandom_range(0, 7) != 0) ? $urandom_range(0, 9) : $urandom;
      post_access(vmmio_pkg::OpWrite, vmmio_pkg::OffQueueSel, vmmio_pkg::Size4, sel);
      post_access(vmmio_pkg::OpRead, vmmio_pkg::OffQueueNumMax, any_size(), $urandom);
      if ($urandom_range(0, 4) != 0) begin
        num = $urandom_range(0, ring_num_max);
      end else begin
        num = 32'(ring_num_max) + $urandom_range(1, 40000);
      end
      post_access(vmmio_pkg::OpWrite, vmmio_pkg::OffQueueNum, any_size(), num);
      post_access(vmmio_pkg::OpRead, vmmio_pkg::OffQueueNum, any_size(), $urandom);
      for (int j = 0; j < 6; j++) begin
        post_access(vmmio_pkg::OpWrite, ring_reg(j), any_size(), $urandom);
      end
      post_access(vmmio_pkg::OpRead, ring_reg($urandom_range(0, 5)), any_size(), $urandom);
      post_access(vmmio_pkg::OpRead, ring_reg($urandom_range(0, 5)), any_size(), $urandom);
      post_access(vmmio_pkg::OpWrite, vmmio_pkg::OffQueueReady, any_size(),
                  ($urandom_range(0, 4) != 0) ? 32'd1 : $urandom_range(0, 1));
      post_access(vmmio_pkg::OpRead, vmmio_pkg::OffQueueReady, any_size(), $urandom);
    end
    post_access(vmmio_pkg::OpWrite, vmmio_pkg::OffStatus, vmmio_pkg::Size4,
                StAcknowledge | StDriver | StFeaturesOk | StDriverOk);
    acts = $urandom_range(1, 8);
    for (int i = 0; i < acts; i++) begin
      case ($urandom_range(0, 4))
        0: post_access(vmmio_pkg::OpWrite, vmmio_pkg::OffQueueNotify, any_size(),
                       $urandom_range(0, 1) ? $urandom_range(0, 9) : $urandom);
        1: post_access(vmmio_pkg::OpUsed, 12'($urandom), 4'($urandom), $urandom);
        2: post_access(vmmio_pkg::OpRead, vmmio_pkg::OffIntStatus, any_size(), $urandom);
        3: post_access(vmmio_pkg::OpWrite, vmmio_pkg::OffIntAck, any_size(),
                       $urandom_range(0, 1) ? IntUsedRing : $urandom);
        default: post_access(vmmio_pkg::OpWrite, vmmio_pkg::OffQueueReady, any_size(),
                             $urandom_range(0, 1));
      endcase
    end
  endtask

  // Random traffic: mostly complete bring-ups with random content, the rest noise.
  task automatic post_random(input int n);
    int first;
    first = queued_count;
    while (queued_count - first < n) begin
      if ($urandom_range(0, 9) < 7) begin
        post_bringup();
      end else begin
        post_noise($urandom_range(1, 20));
      end
    end
  endtask

  // Hold the sender until every transaction has been driven and answered.
  task automatic wait_drained();
    @(negedge clk_i);
    while (bus_requests.size() != 0 || start || predicted_replies.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (2) @(negedge clk_i);
  endtask

  // APB write: setup cycle, then access cycle held until pready completes the transfer.
  task automatic cfg_write(input logic [2:0] idx, input logic [63:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) begin
      @(posedge clk_i);
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic cfg_all(input logic [15:0] dev, input logic [31:0] ven,
                         input logic [63:0] feat, input logic [3:0] nq,
                         input logic [15:0] nmax);
    cfg_write(vmmio_pkg::CfgDeviceId, 64'(dev));
    cfg_write(vmmio_pkg::CfgVendorId, 64'(ven));
    cfg_write(vmmio_pkg::CfgDeviceFeat, feat);
    cfg_write(vmmio_pkg::CfgQueueCount, 64'(nq));
    cfg_write(vmmio_pkg::CfgQueueSizeMax, 64'(nmax));
  endtask

  // Stimulus. Every configuration change happens with the block drained.
  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset configuration: no queues, only VERSION_1 offered.
    post_random(150);
    wait_drained();

    // Upper extremes of ids, queue count and ring size; only the low sixteen feature bits
    // and VERSION_1 offered so that a driver can over-ask.
    cfg_all(16'hffff, 32'hffff_ffff, 64'h0000_0000_0000_ffff, 4'd8, 16'h8000);

    // Directed transactions.
    post_access(vmmio_pkg::OpRead, vmmio_pkg::OffMagic, vmmio_pkg::Size4, '0);
    post_access(vmmio_pkg::OpRead, vmmio_pkg::OffVersion, vmmio_pkg::Size2, '0);
    post_access(vmmio_pkg::OpRead, vmmio_pkg::OffDeviceId, vmmio_pkg::Size1, '0);
    post_access(vmmio_pkg::OpRead, vmmio_pkg::OffVendorId, vmmio_pkg::Size4, '0);
    post_access(vmmio_pkg::OpWrite, vmmio_pkg::OffDevFeatSel, vmmio_pkg::Size4,
                32'hffff_ffff);
    post_access(vmmio_pkg::OpRead, vmmio_pkg::OffDevFeat, vmmio_pkg::Size4, '0);
    // Illegal sizes: zero, eight and all ones.
    post_access(vmmio_pkg::OpRead, vmmio_pkg::OffMagic, 4'd0, '0);
    post_access(vmmio_pkg::OpWrite, vmmio_pkg::OffStatus, 4'd8, StAcknowledge);
    post_access(vmmio_pkg::OpRead, vmmio_pkg::OffMagic, 4'hf, '0);
    // The unused opcode, then a used-ring event with an illegal size and stray offset.
    post_access(OpUnused, 12'hfff, vmmio_pkg::Size4, 32'hffff_ffff);
    post_access(vmmio_pkg::OpUsed, 12'hfff, 4'd0, 32'hffff_ffff);
    // Byte-wide acknowledge, config space both ways, a misaligned read.
    post_access(vmmio_pkg::OpWrite, vmmio_pkg::OffIntAck, vmmio_pkg::Size1, 32'hffff_ffff);
    post_access(vmmio_pkg::OpRead, ConfigSpaceStart, vmmio_pkg::Size4, '0);
    post_access(vmmio_pkg::OpWrite, 12'hfff, vmmio_pkg::Size1, 32'hffff_ffff);
    post_access(vmmio_pkg::OpRead, vmmio_pkg::OffMagic | 12'h001, vmmio_pkg::Size4, '0);
    // Over-asking for features must knock FEATURES_OK out of the stored status.
    post_access(vmmio_pkg::OpWrite, vmmio_pkg::OffDrvFeatSel, vmmio_pkg::Size4, 32'd1);
    post_access(vmmio_pkg::OpWrite, vmmio_pkg::OffDrvFeat, vmmio_pkg::Size4, 32'hffff_ffff);
    post_access(vmmio_pkg::OpWrite, vmmio_pkg::OffStatus, vmmio_pkg::Size4,
                StAcknowledge | StDriver | StFeaturesOk);
    post_access(vmmio_pkg::OpRead, vmmio_pkg::OffStatus, vmmio_pkg::Size4, '0);
    // Highest valid queue: oversize ring, ready, notify with the widest index.
    post_access(vmmio_pkg::OpWrite, vmmio_pkg::OffQueueSel, vmmio_pkg::Size4, 32'd7);
    post_access(vmmio_pkg::OpWrite, vmmio_pkg::OffQueueNum, vmmio_pkg::Size4, 32'h8001);
    post_access(vmmio_pkg::OpWrite, vmmio_pkg::OffQueueReady, vmmio_pkg::Size4, 32'd1);
    post_access(vmmio_pkg::OpWrite, vmmio_pkg::OffQueueNotify, vmmio_pkg::Size4,
                32'hffff_ffff);
    // First queue past the count, then a status reset.
    post_access(vmmio_pkg::OpWrite, vmmio_pkg::OffQueueSel, vmmio_pkg::Size4, 32'd8);
    post_access(vmmio_pkg::OpRead, vmmio_pkg::OffQueueNumMax, vmmio_pkg::Size4, '0);
    post_access(vmmio_pkg::OpWrite, vmmio_pkg::OffStatus, vmmio_pkg::Size4, '0);

    post_random(450);
    wait_drained();

    // Lower extremes.
    cfg_all('0, '0, '0, '0, '0);
    post_random(300);
    wait_drained();

    // Random configuration, with a drained pause half way.
    cfg_all(16'($urandom), $urandom, {$urandom, $urandom}, 4'($urandom_range(1, 8)),
            16'($urandom_range(0, 32768)));
    post_random(250);
    wait_drained();
    post_random(250);
    wait_drained();

    // Everything offered, a modest ring size, and no idling for the closing stretch.
    cfg_all(16'($urandom), $urandom, 64'hffff_ffff_ffff_ffff, 4'd8, 16'd256);
    post_random(300);
    while (bus_requests.size() != 0) begin
      @(negedge clk_i);
    end
    bursty = 1'b0;
    post_random(250);

    wait_drained();
    repeat (4) @(negedge clk_i);
    if (fail_count == 0) begin
      $display(PassMsg);
    end else begin
      $display("tb_virtio_mmio_register_block: done, errors");
    end
    $finish;
  end

endmodule
